// ===== rtl/mnpp_pkg.sv =====
`timescale 1ns / 1ps

package mnpp_pkg;

  // Field widths of one gate.
  localparam int unsigned MASK_W = 32;
  localparam int unsigned TGT_W  = 5;
  localparam int unsigned KIND_W = 2;

  // Default number of wires.
  localparam int unsigned WIRES_DEF = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_EVERY_WIRE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIRE_MASK = 1'd1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_GATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MASK_W-1:0] control_mask;
    logic [MASK_W-1:0] polarity;
    logic [TGT_W-1:0]  target;
  } result_t;

endpackage

// ===== rtl/mct_not_phase_propagator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
// in        in         in_valid/in_ready      control mask, polarity, target, final flag
// out       out        out_valid/out_ready    kind, control mask, polarity, target
//
// Controlled gates go from the input to the result register. A new gate is taken every
// cycle outside a flush and, for a controlled gate, with the skid entry free, so a
// stalled output fills it before the input stops. A final gate brings a restoring NOT
// per kept wire with phase set, then the end marker; the single flush sequencer holds
// the input. Reset (rst_n low, synchronous) clears all phases and both registers.
module mct_not_phase_propagator #(
  parameter int unsigned WIRES = mnpp_pkg::WIRES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mnpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mnpp_pkg::MASK_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mnpp_pkg::MASK_W-1:0]    in_control_mask,
  input  logic [mnpp_pkg::MASK_W-1:0]    in_control_polarity,
  input  logic [mnpp_pkg::TGT_W-1:0]     in_target_wire,
  input  logic                           in_final_gate,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mnpp_pkg::KIND_W-1:0]    out_result_kind,
  output logic [mnpp_pkg::MASK_W-1:0]    out_result_control_mask,
  output logic [mnpp_pkg::MASK_W-1:0]    out_result_polarity,
  output logic [mnpp_pkg::TGT_W-1:0]     out_result_target
);
  import mnpp_pkg::*;

  // Only wires that fit the 32-bit masks carry a phase.
  localparam int unsigned PHASE_W = (WIRES < MASK_W) ? WIRES : MASK_W;
  localparam int unsigned IDX_W   = (PHASE_W > 1) ? $clog2(PHASE_W) : 1;

  // Configuration registers.
  logic               keep_every_r;
  logic [MASK_W-1:0]  out_mask_r;

  // Input register.
  logic               in_vld_r;
  logic [MASK_W-1:0]  in_mask_r;
  logic [MASK_W-1:0]  in_pol_r;
  logic [TGT_W-1:0]   in_tgt_r;
  logic               in_final_r;

  // Phase state and flush sequencer.
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] todo_r, todo_nxt;
  logic               flush_r, flush_nxt;

  // Result register and skid entry.
  logic               out_vld_r, skid_vld_r;
  result_t            out_item_r, skid_item_r;

  logic               consume;
  logic               push;
  logic               push_ready;
  result_t            push_item;
  logic [PHASE_W-1:0] phase_tog;
  logic [PHASE_W-1:0] keep_mask;
  logic [IDX_W-1:0]   low_idx;
  logic               out_take;

  assign cfg_ready  = 1'b1;
  assign push_ready = !skid_vld_r;
  assign in_ready   = !in_vld_r || consume;
  assign out_take   = out_vld_r && out_ready;

  // Configuration transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_every_r <= 1'b0;
      out_mask_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEEP_EVERY_WIRE:  keep_every_r <= cfg_data[0];
        REG_OUTPUT_WIRE_MASK: out_mask_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: loaded on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mask_r  <= in_control_mask;
      in_pol_r   <= in_control_polarity;
      in_tgt_r   <= in_target_wire;
      in_final_r <= in_final_gate;
    end
  end

  // Phase after a NOT; targets beyond the wire count leave it alone.
  always_comb begin
    phase_tog = phase_r;
    if ({1'b0, in_tgt_r} < (TGT_W + 1)'(PHASE_W)) begin
      phase_tog = phase_r ^ (PHASE_W'(1) << in_tgt_r[IDX_W-1:0]);
    end
  end

  assign keep_mask = keep_every_r ? '1 : out_mask_r[PHASE_W-1:0];

  // Lowest wire still waiting for a restoring NOT.
  always_comb begin
    low_idx = '0;
    for (int i = PHASE_W - 1; i >= 0; i--) begin
      if (todo_r[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  // Gate processing and flush sequencing.
  always_comb begin
    consume   = 1'b0;
    push      = 1'b0;
    push_item = '0;
    phase_nxt = phase_r;
    todo_nxt  = todo_r;
    flush_nxt = flush_r;
    if (flush_r) begin
      if (push_ready) begin
        push = 1'b1;
        if (todo_r != '0) begin
          push_item.kind   = KIND_NOT;
          push_item.target = TGT_W'(low_idx);
          todo_nxt         = todo_r & (todo_r - PHASE_W'(1));
        end else begin
          push_item.kind = KIND_END;
          flush_nxt      = 1'b0;
        end
      end
    end else if (in_vld_r) begin
      if (in_mask_r == '0) begin
        // A NOT only moves the phase.
        consume = 1'b1;
        if (in_final_r) begin
          todo_nxt  = keep_mask & phase_tog;
          phase_nxt = '0;
          flush_nxt = 1'b1;
        end else begin
          phase_nxt = phase_tog;
        end
      end else if (push_ready) begin
        // A controlled gate goes out with phase-adjusted polarities.
        consume                = 1'b1;
        push                   = 1'b1;
        push_item.kind         = KIND_GATE;
        push_item.control_mask = in_mask_r;
        push_item.polarity     = (in_pol_r ^ MASK_W'(phase_r)) & in_mask_r;
        push_item.target       = in_tgt_r;
        if (in_final_r) begin
          todo_nxt  = keep_mask & phase_r;
          phase_nxt = '0;
          flush_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      flush_r <= 1'b0;
      todo_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      flush_r <= flush_nxt;
      todo_r  <= todo_nxt;
    end
  end

  // Result register with skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_take) begin
      out_vld_r  <= skid_vld_r || push;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_take) begin
      out_item_r <= skid_vld_r ? skid_item_r : push_item;
    end else if (push) begin
      skid_item_r <= push_item;
    end
  end

  assign out_valid               = out_vld_r;
  assign out_result_kind         = out_item_r.kind;
  assign out_result_control_mask = out_item_r.control_mask;
  assign out_result_polarity     = out_item_r.polarity;
  assign out_result_target       = out_item_r.target;

endmodule

// ===== rtl/mnpp_checker.sv =====
`timescale 1ns / 1ps

module mnpp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mnpp_pkg::KIND_W-1:0]    out_result_kind,
  input logic [mnpp_pkg::MASK_W-1:0]    out_result_control_mask,
  input logic [mnpp_pkg::MASK_W-1:0]    out_result_polarity,
  input logic [mnpp_pkg::TGT_W-1:0]     out_result_target
);
  import mnpp_pkg::*;

  // A stalled result stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_result_control_mask) && $stable(out_result_polarity)
      && $stable(out_result_target))
    else $error("result changed while stalled");

  // Emitted gates have controls and polarities only on control wires.
  a_gate_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_GATE |->
      out_result_control_mask != '0 && (out_result_polarity & ~out_result_control_mask) == '0)
    else $error("malformed controlled gate");

  // Restoring NOTs carry no controls.
  a_not_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_NOT |->
      out_result_control_mask == '0 && out_result_polarity == '0)
    else $error("restoring NOT has controls");

  // The end marker has zero mask, polarity and target.
  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_END |->
      out_result_control_mask == '0 && out_result_polarity == '0 && out_result_target == '0)
    else $error("end marker has nonzero fields");

endmodule

bind mct_not_phase_propagator mnpp_checker u_mnpp_checker (.*);

// ===== tb/mnpp_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, gate and result channels of the phase propagator.
// It keeps its own copy of the wire phases, works out the rewritten gate stream
// for every gate transfer, and compares each result transfer with the oldest
// entry still waiting.
module mnpp_scoreboard #(
  parameter int unsigned WIRES = mnpp_pkg::WIRES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mnpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mnpp_pkg::MASK_W-1:0]    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [mnpp_pkg::MASK_W-1:0]    in_control_mask,
  input  logic [mnpp_pkg::MASK_W-1:0]    in_control_polarity,
  input  logic [mnpp_pkg::TGT_W-1:0]     in_target_wire,
  input  logic                           in_final_gate,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [mnpp_pkg::KIND_W-1:0]    out_result_kind,
  input  logic [mnpp_pkg::MASK_W-1:0]    out_result_control_mask,
  input  logic [mnpp_pkg::MASK_W-1:0]    out_result_polarity,
  input  logic [mnpp_pkg::TGT_W-1:0]     out_result_target,
  output int                             fail_count,
  output int                             pending
);
  import mnpp_pkg::*;

  // Wires that exist; phases of wires beyond them stay zero.
  localparam logic [MASK_W-1:0] LIVE_WIRES =
    (WIRES >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << WIRES) - MASK_W'(1));

  logic [MASK_W-1:0] phase_bits;
  logic              restore_all;
  logic [MASK_W-1:0] output_wires;
  result_t           expected_gates[$];
  int                mismatches = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic queue_gate(input logic [KIND_W-1:0] kind, input logic [MASK_W-1:0] mask,
                            input logic [MASK_W-1:0] pol, input logic [TGT_W-1:0] tgt);
    result_t r;
    r.kind = kind;
    r.control_mask = mask;
    r.polarity = pol;
    r.target = tgt;
    expected_gates.push_back(r);
  endtask

  // One gate: a NOT only moves the phase, a controlled gate goes out with its
  // polarities flipped by the phases, and the last gate flushes the kept phases.
  task automatic propagate_gate(input logic [MASK_W-1:0] mask, input logic [MASK_W-1:0] pol,
                                input logic [TGT_W-1:0] tgt, input logic last);
    logic [MASK_W-1:0] flush;
    if (mask == '0) begin
      phase_bits = (phase_bits ^ (MASK_W'(1) << tgt)) & LIVE_WIRES;
    end else begin
      queue_gate(KIND_GATE, mask, (pol ^ phase_bits) & mask, tgt);
    end
    if (last) begin
      flush = (restore_all ? LIVE_WIRES : (output_wires & LIVE_WIRES)) & phase_bits;
      for (int w = 0; w < MASK_W; w++) begin
        if (flush[w]) begin
          queue_gate(KIND_NOT, '0, '0, TGT_W'(w));
        end
      end
      queue_gate(KIND_END, '0, '0, '0);
      phase_bits = '0;
    end
  endtask

  // Compare one result transfer field by field with the oldest expectation.
  task automatic check_result(input result_t got);
    result_t want;
    if (expected_gates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: unexpected result kind=%0d mask=%h pol=%h tgt=%0d",
                 got.kind, got.control_mask, got.polarity, got.target);
      end
    end else begin
      want = expected_gates.pop_front();
      if (got.kind !== want.kind || got.control_mask !== want.control_mask ||
          got.polarity !== want.polarity || got.target !== want.target) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: expected kind=%0d mask=%h pol=%h tgt=%0d,",
                   want.kind, want.control_mask, want.polarity, want.target,
                   " got kind=%0d mask=%h pol=%h tgt=%0d",
                   got.kind, got.control_mask, got.polarity, got.target);
        end
      end
    end
  endtask

  // Results are checked before the gate of the same edge is predicted, since
  // a gate cannot come out on the edge it goes in.
  always @(posedge clk) begin
    result_t got;
    if (!rst_n) begin
      phase_bits = '0;
      restore_all = 1'b0;
      output_wires = '0;
      expected_gates.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.kind = out_result_kind;
        got.control_mask = out_result_control_mask;
        got.polarity = out_result_polarity;
        got.target = out_result_target;
        check_result(got);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEEP_EVERY_WIRE: restore_all = cfg_data[0];
          REG_OUTPUT_WIRE_MASK: output_wires = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        propagate_gate(in_control_mask, in_control_polarity, in_target_wire, in_final_gate);
      end
    end
    fail_count <= mismatches;
    pending <= expected_gates.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mnpp_pkg::*;

  localparam int LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MASK_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [MASK_W-1:0]    in_control_mask;
  logic [MASK_W-1:0]    in_control_polarity;
  logic [TGT_W-1:0]     in_target_wire;
  logic                 in_final_gate;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    out_result_kind;
  logic [MASK_W-1:0]    out_result_control_mask;
  logic [MASK_W-1:0]    out_result_polarity;
  logic [TGT_W-1:0]     out_result_target;
  int                   fail_count;
  int                   pending;
  logic                 calm;
  int                   stall_left = 0;
  int                   cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mct_not_phase_propagator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_control_mask(in_control_mask),
    .in_control_polarity(in_control_polarity), .in_target_wire(in_target_wire),
    .in_final_gate(in_final_gate),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_result_control_mask(out_result_control_mask),
    .out_result_polarity(out_result_polarity), .out_result_target(out_result_target)
  );

  mnpp_scoreboard u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_control_mask(in_control_mask),
    .in_control_polarity(in_control_polarity), .in_target_wire(in_target_wire),
    .in_final_gate(in_final_gate),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_result_control_mask(out_result_control_mask),
    .out_result_polarity(out_result_polarity), .out_result_target(out_result_target),
    .fail_count(fail_count), .pending(pending)
  );

  // Result side: random stall bursts, none started once calm.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One gate transfer, sometimes after an idle burst on the input side.
  task automatic send_gate(input logic [MASK_W-1:0] mask, input logic [MASK_W-1:0] pol,
                           input int tgt, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_control_mask <= mask;
    in_control_polarity <= pol;
    in_target_wire <= TGT_W'(tgt);
    in_final_gate <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every expected result is out, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      1: return $urandom & $urandom;
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random circuits of 1 to 12 gates, each closed by a final gate.
  task automatic run_circuits(input int quota);
    int sent;
    int len;
    sent = 0;
    while (sent < quota) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) < 4) begin
          send_gate('0, $urandom, $urandom_range(0, 31), i == len - 1);
        end else begin
          send_gate(pick_mask(), $urandom, $urandom_range(0, 31), i == len - 1);
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_control_mask = '0;
    in_control_polarity = '0;
    in_target_wire = '0;
    in_final_gate = 1'b0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Restore every wire: NOTs at both ends, a toggle back, full masks,
    // target among its controls, final controlled gate and final NOT.
    write_reg(REG_KEEP_EVERY_WIRE, MASK_W'(1));
    write_reg(REG_OUTPUT_WIRE_MASK, '0);
    send_gate('0, '0, 0, 1'b0);
    send_gate('0, '1, 31, 1'b0);
    send_gate('0, '0, 7, 1'b0);
    send_gate('0, '0, 7, 1'b0);
    send_gate('1, '0, 3, 1'b0);
    send_gate('1, '1, 31, 1'b0);
    send_gate(32'h0000_0001, 32'hFFFF_FFFE, 0, 1'b0);
    send_gate(32'h8000_0000, 32'h8000_0000, 0, 1'b1);
    send_gate('0, '0, 4, 1'b1);
    send_gate(32'h0000_0005, '0, 2, 1'b1);
    settle();

    // Output wires only, with no output wires: the flush is just the end marker.
    write_reg(REG_KEEP_EVERY_WIRE, '0);
    send_gate('0, '0, 2, 1'b0);
    send_gate('0, '0, 9, 1'b0);
    send_gate(32'h0000_0004, '0, 2, 1'b1);
    settle();

    // Every wire an output.
    write_reg(REG_OUTPUT_WIRE_MASK, '1);
    send_gate('0, '0, 30, 1'b0);
    send_gate('0, '0, 1, 1'b1);

    // Random phases under changing settings; the last one runs without idling.
    for (int p = 0; p < 4; p++) begin
      settle();
      write_reg(REG_KEEP_EVERY_WIRE, (p == 0) ? MASK_W'(1) :
                (p == 3) ? MASK_W'($urandom_range(0, 1)) : '0);
      write_reg(REG_OUTPUT_WIRE_MASK, (p == 2) ? ($urandom & $urandom) : $urandom);
      if (p == 3) begin
        calm <= 1'b1;
      end
      if (p == 0) begin
        // Every phase set, then a final controlled gate: the longest flush.
        for (int w = 0; w < MASK_W; w++) begin
          send_gate('0, $urandom, w, 1'b0);
        end
        send_gate($urandom | MASK_W'(1), $urandom, $urandom_range(0, 31), 1'b1);
        run_circuits(30);
      end else begin
        run_circuits(40);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
